// ===== rtl/merge_sorter_core_assert.svh =====
// assertion macros for the merge sorter core
// included by merge_sorter_core.sv, no other dependencies
`ifndef MERGE_SORTER_CORE_ASSERT_SVH
`define MERGE_SORTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("merge_sorter_core: same-cycle check failed");

`define MSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("merge_sorter_core: next-cycle check failed");

`else

`define MSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define MSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ms_pkg.sv =====
// shared constants, types and helpers of the merge sorter core
// no dependencies
`default_nettype none

package ms_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 32;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CNT_W:0]    cnt_wide_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic start;
    cnt_t n;
  } merge_ctl_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } ram_wr_t;

  typedef struct packed {
    logic busy;
    logic pass_end;
    logic done;
  } merge_stat_t;

  function automatic cnt_t min_cnt(input cnt_wide_t a, input cnt_t n);
    cnt_t r;
    if (a > {1'b0, n}) begin
      r = n;
    end else begin
      r = a[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ms_ram.sv =====
// generic simple dual-port ram: one write port, two registered read ports
// write-first on an address collision, no dependencies
`default_nettype none

module ms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr_a)) begin
      rdata_a <= wdata;
    end else begin
      rdata_a <= mem[raddr_a];
    end
    if (we && (waddr == raddr_b)) begin
      rdata_b <= wdata;
    end else begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ms_merge.sv =====
// merge pass engine: walks bottom-up merge passes, one element per cycle
// depends on ms_pkg
`default_nettype none

module ms_merge (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ms_pkg::merge_ctl_t  ctl,
  input  wire ms_pkg::word_t       rd_a,
  input  wire ms_pkg::word_t       rd_b,
  output ms_pkg::addr_t            raddr_a,
  output ms_pkg::addr_t            raddr_b,
  output ms_pkg::ram_wr_t          wr,
  output ms_pkg::merge_stat_t      stat
);

  logic          busy_r, busy_nxt;
  ms_pkg::cnt_t  n_r, n_nxt;
  ms_pkg::cnt_t  w_r, w_nxt;
  ms_pkg::cnt_t  i_r, i_nxt;
  ms_pkg::cnt_t  j_r, j_nxt;
  ms_pkg::cnt_t  k_r, k_nxt;
  ms_pkg::cnt_t  mid_r, mid_nxt;
  ms_pkg::cnt_t  hi_r, hi_nxt;

  logic          take_a;
  logic          blk_end;
  logic          pass_end;
  logic          done;
  ms_pkg::cnt_t  k_inc;
  ms_pkg::cnt_t  w_dbl;
  ms_pkg::cnt_t  nb_mid, nb_hi;
  ms_pkg::cnt_t  np_mid, np_hi;
  ms_pkg::cnt_t  st_hi;

  always_comb begin
    take_a   = (i_r < mid_r) && ((j_r >= hi_r) || ($signed(rd_a) <= $signed(rd_b)));
    k_inc    = k_r + ms_pkg::CNT_W'(1);
    blk_end  = (k_inc == hi_r);
    pass_end = blk_end && (hi_r == n_r);
    w_dbl    = {w_r[ms_pkg::CNT_W-2:0], 1'b0};
    done     = pass_end && (w_dbl >= n_r);
    nb_mid   = ms_pkg::min_cnt({1'b0, hi_r} + {1'b0, w_r}, n_r);
    nb_hi    = ms_pkg::min_cnt({1'b0, hi_r} + {w_r, 1'b0}, n_r);
    np_mid   = ms_pkg::min_cnt({1'b0, w_dbl}, n_r);
    np_hi    = ms_pkg::min_cnt({w_dbl, 1'b0}, n_r);
    st_hi    = ms_pkg::min_cnt(ms_pkg::cnt_wide_t'(2), ctl.n);
  end

  always_comb begin
    busy_nxt = busy_r;
    n_nxt    = n_r;
    w_nxt    = w_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    mid_nxt  = mid_r;
    hi_nxt   = hi_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      n_nxt    = ctl.n;
      w_nxt    = ms_pkg::CNT_W'(1);
      i_nxt    = '0;
      mid_nxt  = ms_pkg::CNT_W'(1);
      j_nxt    = ms_pkg::CNT_W'(1);
      hi_nxt   = st_hi;
      k_nxt    = '0;
    end else if (busy_r) begin
      if (!blk_end) begin
        if (take_a) begin
          i_nxt = i_r + ms_pkg::CNT_W'(1);
        end else begin
          j_nxt = j_r + ms_pkg::CNT_W'(1);
        end
        k_nxt = k_inc;
      end else if (!pass_end) begin
        // next pair of runs in this pass
        i_nxt   = hi_r;
        mid_nxt = nb_mid;
        j_nxt   = nb_mid;
        hi_nxt  = nb_hi;
        k_nxt   = k_inc;
      end else if (!done) begin
        w_nxt   = w_dbl;
        i_nxt   = '0;
        mid_nxt = np_mid;
        j_nxt   = np_mid;
        hi_nxt  = np_hi;
        k_nxt   = '0;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    n_r   <= n_nxt;
    w_r   <= w_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
  end

  // read the heads at the next pointer values so the registered data lines up with the pointers
  assign raddr_a       = i_nxt[ms_pkg::ADDR_W-1:0];
  assign raddr_b       = j_nxt[ms_pkg::ADDR_W-1:0];
  assign wr.en         = busy_r;
  assign wr.addr       = k_r[ms_pkg::ADDR_W-1:0];
  assign wr.data       = take_a ? rd_a : rd_b;
  assign stat.busy     = busy_r;
  assign stat.pass_end = busy_r && pass_end;
  assign stat.done     = busy_r && done;

endmodule

`default_nettype wire

// ===== rtl/merge_sorter_core.sv =====
// merge sorter core: collects a set of signed words, merge sorts, streams out
// depends on ms_pkg, ms_ram, ms_merge and merge_sorter_core_assert.svh
//
// usage:
//   in_*  : one signed 32-bit value per transaction, in_tlast closes the set.
//   out_* : the set in ascending order, out_tlast on the greatest value,
//           out_tuser high on every value of a set that lost items.
//   up to 64 values are held; further items are dropped but still close a set.
// timing, for a set of n held values:
//   load : in_tready high while collecting.
//   sort : ceil(log2 n) merge passes, each value written once per pass through
//          the single write port of the target one of the ping-pong stores.
//   emit : one value per cycle while out_tready is high; first value is
//          offered in the cycle after the sort ends.
//   one set is handled at a time: in_tready is low from the closing item
//   until the last sorted value is taken.
// reset clears the item count, overflow flag and control; store contents
// are left as they are. a stall on out_tready holds the offered value and
// freezes the block.
`default_nettype none

`include "merge_sorter_core_assert.svh"

module merge_sorter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] value_res
  output logic             out_tlast,
  output logic             out_tuser   // [0] overflow
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  ms_pkg::cnt_t        cnt_r, cnt_nxt;
  logic                drop_r, drop_nxt;
  logic                sel_r, sel_nxt;
  ms_pkg::cnt_t        e_r, e_nxt;

  logic                in_acc;
  logic                out_acc;
  logic                has_room;
  logic                last_val;
  ms_pkg::merge_ctl_t  m_ctl;
  ms_pkg::merge_stat_t m_stat;
  ms_pkg::ram_wr_t     m_wr;
  ms_pkg::addr_t       m_raddr_a, m_raddr_b;
  ms_pkg::addr_t       raddr_a;
  ms_pkg::word_t       r0a, r0b, r1a, r1b;
  ms_pkg::word_t       src_a, src_b;
  logic                we0, we1;
  ms_pkg::addr_t       waddr0;
  ms_pkg::word_t       wdata0;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign has_room  = (cnt_r < ms_pkg::CNT_W'(ms_pkg::MAX_ITEMS));
  assign last_val  = (e_r == (cnt_r - ms_pkg::CNT_W'(1)));

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    drop_nxt    = drop_r;
    sel_nxt     = sel_r;
    e_nxt       = e_r;
    m_ctl.start = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            cnt_nxt = cnt_r + ms_pkg::CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            sel_nxt = 1'b0;
            e_nxt   = '0;
            if (cnt_nxt > ms_pkg::CNT_W'(1)) begin
              m_ctl.start = 1'b1;
              state_nxt   = ST_SORT;
            end else begin
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_SORT: begin
        if (m_stat.pass_end) begin
          sel_nxt = ~sel_r;
        end
        if (m_stat.done) begin
          e_nxt     = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last_val) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            e_nxt     = '0;
            state_nxt = ST_LOAD;
          end else begin
            e_nxt = e_r + ms_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    m_ctl.n = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      sel_r   <= 1'b0;
      e_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      sel_r   <= sel_nxt;
      e_r     <= e_nxt;
    end
  end

  ms_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (m_ctl),
    .rd_a    (src_a),
    .rd_b    (src_b),
    .raddr_a (m_raddr_a),
    .raddr_b (m_raddr_b),
    .wr      (m_wr),
    .stat    (m_stat)
  );

  // store 0 takes the incoming set; the stores swap roles every pass
  assign raddr_a = (state_nxt == ST_EMIT) ? e_nxt[ms_pkg::ADDR_W-1:0] : m_raddr_a;
  assign we0     = (in_acc && has_room) || (m_wr.en && sel_r);
  assign waddr0  = in_acc ? cnt_r[ms_pkg::ADDR_W-1:0] : m_wr.addr;
  assign wdata0  = in_acc ? in_tdata : m_wr.data;
  assign we1     = m_wr.en && !sel_r;

  ms_ram #(
    .WIDTH (ms_pkg::DATA_W),
    .DEPTH (ms_pkg::MAX_ITEMS)
  ) u_ram0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (raddr_a),
    .raddr_b (m_raddr_b),
    .rdata_a (r0a),
    .rdata_b (r0b)
  );

  ms_ram #(
    .WIDTH (ms_pkg::DATA_W),
    .DEPTH (ms_pkg::MAX_ITEMS)
  ) u_ram1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (m_wr.addr),
    .wdata   (m_wr.data),
    .raddr_a (raddr_a),
    .raddr_b (m_raddr_b),
    .rdata_a (r1a),
    .rdata_b (r1b)
  );

  assign src_a = sel_r ? r1a : r0a;
  assign src_b = sel_r ? r1b : r0b;

  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = src_a;
  assign out_tlast  = last_val;
  assign out_tuser  = drop_r;

  `MSC_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= ms_pkg::CNT_W'(ms_pkg::MAX_ITEMS))
  `MSC_ASSERT_IMPL(a_sort_busy, clk, rst_n, state_r == ST_SORT, m_stat.busy)
  `MSC_ASSERT_IMPL(a_emit_nonempty, clk, rst_n, out_tvalid, cnt_r != '0)
  `MSC_ASSERT_NEXT(a_set_done, clk, rst_n, out_acc && out_tlast, in_tready && (cnt_r == '0) && !drop_r)

endmodule

`default_nettype wire

// ===== dv/merge_sorter_checker.sv =====
// checker for merge_sorter_core: watches both stream channels, keeps the collected set,
// sorts it on the closing transaction and compares every sorted value in order
// depends on ms_pkg for the store capacity
`timescale 1ns / 1ps

module merge_sorter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  input  logic        end_of_run,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  logic signed [31:0] collected [$];
  logic               set_lost;
  // {overflow, last, value}
  logic [33:0]        sorted_values [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    set_lost     = 1'b0;
  end

  task automatic report_failure(input string msg);
    if (fail_count < 10) begin
      $display("%0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    logic [33:0]        want;
    logic signed [31:0] vals [$];
    logic signed [31:0] key;
    int                 n;
    int                 i;
    int                 j;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (sorted_values.size() == 0) begin
          report_failure($sformatf("unexpected result: value %0d last %0b overflow %0b",
                                   $signed(out_tdata), out_tlast, out_tuser));
        end else begin
          want = sorted_values.pop_front();
          if (want[31:0] !== out_tdata || want[32] !== out_tlast || want[33] !== out_tuser) begin
            report_failure($sformatf(
              "mismatch: expected value %0d last %0b overflow %0b, got value %0d last %0b overflow %0b",
              $signed(want[31:0]), want[32], want[33],
              $signed(out_tdata), out_tlast, out_tuser));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (collected.size() < ms_pkg::MAX_ITEMS) begin
          collected.push_back(in_tdata);
        end else begin
          set_lost = 1'b1;
        end
        if (in_tlast) begin
          vals = collected;
          n = vals.size();
          for (i = 1; i < n; i++) begin
            key = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > key) begin
              vals[j + 1] = vals[j];
              j--;
            end
            vals[j + 1] = key;
          end
          for (i = 0; i < n; i++) begin
            sorted_values.push_back({set_lost, (i == n - 1), vals[i]});
          end
          collected.delete();
          set_lost = 1'b0;
        end
      end
      pending = sorted_values.size();
    end
  end

  always @(posedge end_of_run) begin
    if (sorted_values.size() != 0) begin
      report_failure($sformatf("%0d sorted values never came out", sorted_values.size()));
    end
  end

endmodule

// ===== dv/merge_sorter_core_tb.sv =====
// testbench top for merge_sorter_core: drives sets of signed values with random gaps and
// output stalls, including one long hold-off; the checker judges every result
// depends on merge_sorter_core, merge_sorter_checker and ms_pkg
`timescale 1ns / 1ps

module merge_sorter_core_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        end_of_run;

  int fail_count;
  int pending;
  int results_seen;
  int items_sent;
  int sets_sent;
  int overflow_sets;
  bit in_burst;
  bit out_burst;
  bit long_hold;

  merge_sorter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  merge_sorter_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .end_of_run  (end_of_run),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 6) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h8000_0001;
          2: v = 32'h7fff_ffff;
          default: v = 32'h7fff_fffe;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // called just after a falling edge, returns just after the falling edge that follows acceptance
  task automatic send_item(input logic [31:0] v, input logic is_last);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_random_set(input int size);
    int k;
    in_burst = ($urandom_range(0, 3) == 0);
    for (k = 0; k < size; k++) begin
      send_item(pick_value(), k == size - 1);
    end
    sets_sent++;
    if (size > ms_pkg::MAX_ITEMS) begin
      overflow_sets++;
    end
  endtask

  // result side: random stalls, bursts of steady readiness, and the long hold-off on request
  initial begin : sink
    int stall;
    out_tready = 1'b0;
    out_burst  = 1'b0;
    long_hold  = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        stall = 600;
        long_hold = 1'b0;
      end else begin
        stall = out_burst ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
      if ($urandom_range(0, 24) == 0) begin
        out_burst = !out_burst;
      end
    end
  end

  initial begin : source
    int size;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    end_of_run    = 1'b0;
    items_sent    = 0;
    sets_sent     = 0;
    overflow_sets = 0;
    in_burst      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single value, the most negative
    send_item(32'h8000_0000, 1'b1);
    // extremes reversed
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    // mixed signs with duplicates
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    // all equal
    send_item(32'h0000_0005, 1'b0);
    send_item(32'h0000_0005, 1'b0);
    send_item(32'h0000_0005, 1'b1);
    // already ascending, then descending apart from the closing zero
    send_item(32'hffff_fffe, 1'b0);
    send_item(32'h0000_0003, 1'b0);
    send_item(32'h0000_0100, 1'b0);
    send_item(32'h5555_5555, 1'b1);
    send_item(32'haaaa_aaaa, 1'b0);
    send_item(32'h8000_0001, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    sets_sent = 6;

    // long hold-off requested at the output while a full set and then an overflowing set keep knocking
    long_hold = 1'b1;
    send_random_set(ms_pkg::MAX_ITEMS);
    send_random_set(ms_pkg::MAX_ITEMS + 2);

    while (items_sent < 280) begin
      case ($urandom_range(0, 19))
        0:                size = ms_pkg::MAX_ITEMS + $urandom_range(1, 6);
        1, 2:             size = $urandom_range(25, ms_pkg::MAX_ITEMS);
        3, 4, 5, 6, 7:    size = $urandom_range(9, 24);
        default:          size = $urandom_range(1, 8);
      endcase
      send_random_set(size);
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    end_of_run = 1'b1;
    @(negedge clk);

    $display("covered %0d input transactions in %0d sets, %0d of them beyond capacity",
             items_sent, sets_sent, overflow_sets);
    $display("checked %0d sorted values, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ms_pkg.sv
rtl/ms_ram.sv
rtl/ms_merge.sv
rtl/merge_sorter_core.sv
dv/merge_sorter_checker.sv
dv/merge_sorter_core_tb.sv
